>>> hdl/hcbp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the bit packer.
package hcbp_pkg;

   localparam int SYMBOLS      = 256;
   localparam int MAX_CODE_LEN = 16;
   localparam int TBL_AW       = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

   localparam int CODE_W  = 16;
   localparam int LEN_W   = 5;
   localparam int BYTE_W  = 8;
   localparam int SYM_W   = 8;
   localparam int ENTRY_W = CODE_W + LEN_W;
   localparam int WIN_W   = BYTE_W + CODE_W;
   localparam int EFF_MAX_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_ENCODE = 2'd1,
      FUNC_FLUSH  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic tbl_wr;    // write table entry from request beat
      logic tbl_rd;    // read table entry for request symbol
      logic calc;      // merge looked-up code into buffer, latch window
      logic emit;      // load one packed byte into output register
      logic sel;       // which window byte to emit
      logic last;      // last byte of this item
      logic flush_out; // load padded buffer into output register, clear buffer
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] n_bytes;  // full bytes pushed out by current lookup
      logic       out_free; // output register can take a byte this cycle
   } ctl_stat_type;

endpackage

>>> hdl/hcbp_ctrl.sv
// Sequencer for table loads, lookups, byte emission and flushes.
module hcbp_ctrl
   import hcbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  func_type     req_func,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic [1:0] nbytes_ff, nbytes_in;
   logic       idx_ff, idx_in;
   logic       is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         nbytes_ff <= 2'd0;
         idx_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         nbytes_ff <= nbytes_in;
         idx_ff    <= idx_in;
      end
   end

   assign is_last = ({1'b0, idx_ff} + 2'd1) == nbytes_ff;

   always_comb begin
      state_in   = state_ff;
      nbytes_in  = nbytes_ff;
      idx_in     = idx_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.sel    = idx_ff;
      cmd.last   = is_last;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_func)
                  FUNC_LOAD:   cmd.tbl_wr = 1'b1;
                  FUNC_ENCODE: begin
                     cmd.tbl_rd = 1'b1;
                     state_in   = ST_LOOK;
                  end
                  FUNC_FLUSH:  state_in = ST_FLUSH;
                  default:     ;
               endcase
            end
         end
         ST_LOOK: begin
            cmd.calc  = 1'b1;
            nbytes_in = stat.n_bytes;
            idx_in    = 1'b0;
            state_in  = (stat.n_bytes == 2'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> hdl/hcbp_dpath.sv
// Code table, bit buffer, packing window and output register.
module hcbp_dpath
   import hcbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic [CODE_W-1:0]   req_code_bits,
   input  logic [LEN_W-1:0]    req_code_length,
   input  ctl_cmd_type         cmd,
   output ctl_stat_type        stat,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_is_flush,
   output logic                rsp_last
);

   logic [ENTRY_W-1:0] tbl_mem [SYMBOLS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_ok_ff;
   logic               sym_ok;
   logic [LEN_W-1:0]   wr_len;

   logic [BYTE_W-1:0]  buf_ff, buf_in;
   logic [3:0]         bc_ff, bc_in;
   logic [WIN_W-1:0]   win_ff;

   logic [CODE_W-1:0]  rd_code, code_left;
   logic [LEN_W-1:0]   rd_len;
   logic [WIN_W-1:0]   win;
   logic [LEN_W-1:0]   total, total_m1;
   logic [1:0]         n_bytes;

   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               out_flush_ff, out_last_ff;

   assign sym_ok = {1'b0, req_symbol} < (SYM_W + 1)'(SYMBOLS);
   assign wr_len = (req_code_length > LEN_W'(EFF_MAX_LEN)) ? LEN_W'(EFF_MAX_LEN)
                                                            : req_code_length;

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr && sym_ok)
         tbl_mem[req_symbol[TBL_AW-1:0]] <= {wr_len, req_code_bits};
      if (cmd.tbl_rd) begin
         rd_data_ff <= tbl_mem[req_symbol[TBL_AW-1:0]];
         rd_ok_ff   <= sym_ok;
      end
   end

   // out-of-range symbol acts as a zero-length code
   assign rd_code = rd_data_ff[CODE_W-1:0];
   assign rd_len  = rd_ok_ff ? rd_data_ff[ENTRY_W-1:CODE_W] : '0;

   // left-align code, place right after the buffered bits
   assign code_left = rd_code << (LEN_W'(CODE_W) - rd_len);
   assign win       = {buf_ff, {CODE_W{1'b0}}} | ({code_left, {BYTE_W{1'b0}}} >> bc_ff);
   assign total     = {1'b0, bc_ff} + rd_len;
   assign total_m1  = total - 5'd1;
   assign n_bytes   = (total == '0) ? 2'd0 : total_m1[4:3];

   always_comb begin
      buf_in = buf_ff;
      bc_in  = bc_ff;
      if (cmd.calc) begin
         case (n_bytes)
            2'd0:    buf_in = win[23:16];
            2'd1:    buf_in = win[15:8];
            default: buf_in = win[7:0];
         endcase
         bc_in = 4'(total - {n_bytes, 3'b000});
      end else if (cmd.flush_out) begin
         buf_in = '0;
         bc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
         bc_ff  <= '0;
      end else begin
         buf_ff <= buf_in;
         bc_ff  <= bc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc)
         win_ff <= win;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.flush_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff  <= cmd.sel ? win_ff[15:8] : win_ff[23:16];
         out_flush_ff <= 1'b0;
         out_last_ff  <= cmd.last;
      end else if (cmd.flush_out) begin
         out_byte_ff  <= buf_ff;
         out_flush_ff <= 1'b1;
         out_last_ff  <= 1'b1;
      end
   end

   assign stat.n_bytes  = n_bytes;
   assign stat.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_is_flush = out_flush_ff;
   assign rsp_last     = out_last_ff;

endmodule

>>> hdl/huffman_code_bit_packer.sv
// Top level: Huffman code bit packer (table load, encode, flush).
//
//  channel | dir | tdata                                  | tuser     | tlast
//  --------+-----+----------------------------------------+-----------+------------
//  req_    | in  | symbol, code_bits, code_length, pad    | func      | -
//  rsp_    | out | out_byte                               | is_flush  | last_of_run
//
// Sequence: load and unused func complete in the accept step. Encode accepts with a
// registered table read, merges into the buffer, then emits each full byte (0..2)
// once the output register is free. Flush accepts, then loads the padded buffer.
// New requests wait until idle. Reset clears buffer, bit count, sequencer and output
// register; the table holds junk until loaded. Output stalls hold the sequencer
// in its emit or flush step; one beat may wait in the output register meanwhile.
module huffman_code_bit_packer
   import hcbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [7:0] symbol, [23:8] code_bits, [28:24] code_length
   input  logic [1:0]  req_tuser,  // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] out_byte
   output logic        rsp_tuser,  // [0] is_flush
   output logic        rsp_tlast
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;
   func_type     req_func;

   assign req_func = func_type'(req_tuser);

   hcbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_func),
      .stat       (stat),
      .cmd        (cmd)
   );

   hcbp_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_symbol      (req_tdata[7:0]),
      .req_code_bits   (req_tdata[23:8]),
      .req_code_length (req_tdata[28:24]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_out_byte    (rsp_tdata),
      .rsp_is_flush    (rsp_tuser),
      .rsp_last        (rsp_tlast)
   );

endmodule
